[rtl/lpfd_pkg.sv]
package lpfd_pkg;

	typedef enum logic [2:0] {
		PH_SHORT   = 3'd0,
		PH_LONG    = 3'd1,
		PH_FLAGS   = 3'd2,
		PH_BODY    = 3'd3,
		PH_DISCARD = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BODY     = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_OVERSIZE = 2'd2,
		KIND_ZERO     = 2'd3
	} kind_t;

	localparam logic [7:0]  ESCAPE_BYTE     = 8'hff;
	localparam logic [2:0]  LONG_LAST_COUNT = 3'd7;
	localparam logic [31:0] MAX_BODY_RESET  = 32'd65536;

endpackage

[rtl/length_prefixed_frame_decoder.sv]
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_ready  | data_byte[7:0]
// out      | out_valid / out_ready| kind[1:0] payload_byte[7:0] frame_flags[7:0]
//          |                      | last_byte
// cfg      | cfg_valid / cfg_ready| max_body_length[31:0]
//
// One word per cycle while out_ready holds; accepted words pass the input register, then the result register.
// The input register feeds the decode logic and the result register directly;
// the 64-bit length compare and remaining-count decrement set the path length.
// A stalled output holds the result register and, once the input register is full,
// drops in_ready. Reset clears the frame state and loads max_body_length = 65536.
module length_prefixed_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  frame_flags,
	output logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] max_body_length
);
	import lpfd_pkg::*;

	// input stage
	logic        valid_s1;
	logic [7:0]  data_s1;
	// result stage
	logic        valid_s2;
	logic [1:0]  kind_s2;
	logic [7:0]  payload_s2;
	logic [7:0]  flags_s2;
	logic        last_s2;

	// frame state
	phase_t      phase_q, phase_n;
	logic [2:0]  lcnt_q, lcnt_n;
	logic [63:0] acc_q, acc_n;
	logic [63:0] rem_q, rem_n;
	logic [7:0]  flags_q, flags_n;
	logic [32:0] max_p1_q;   // max_body_length + 1

	logic        advance;
	logic        emit;
	logic [1:0]  emit_kind;
	logic [7:0]  emit_payload;
	logic [7:0]  emit_flags;
	logic        emit_last;

	logic [63:0] len_w;
	logic [63:0] len_m1;
	logic        len_zero;
	logic        len_over;
	logic        rem_le1;
	logic [63:0] rem_dec;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// completed length: the short byte, or the long length with its final byte
	assign len_w    = (phase_q == PH_LONG) ? {acc_q[55:0], data_s1} : {56'd0, data_s1};
	assign len_m1   = len_w - 64'd1;
	assign len_zero = (len_w == 64'd0);
	// body > max  <=>  len > max + 1
	assign len_over = (|len_w[63:33]) || (len_w[32:0] > max_p1_q);
	assign rem_le1  = (rem_q[63:1] == 63'd0);
	assign rem_dec  = (rem_q != 64'd0) ? (rem_q - 64'd1) : rem_q;

	always_comb begin
		logic len_done;
		len_done     = 1'b0;
		phase_n      = phase_q;
		lcnt_n       = lcnt_q;
		acc_n        = acc_q;
		rem_n        = rem_q;
		flags_n      = flags_q;
		emit         = 1'b0;
		emit_kind    = KIND_BODY;
		emit_payload = 8'd0;
		emit_flags   = 8'd0;
		emit_last    = 1'b0;
		case (phase_q)
			PH_LONG: begin
				acc_n  = len_w;
				lcnt_n = lcnt_q + 3'd1;
				if (lcnt_q == LONG_LAST_COUNT) begin
					len_done = 1'b1;
				end
			end
			PH_FLAGS: begin
				flags_n = data_s1;
				if (rem_q == 64'd0) begin
					phase_n    = PH_SHORT;
					emit       = 1'b1;
					emit_kind  = KIND_EMPTY;
					emit_flags = data_s1;
					emit_last  = 1'b1;
				end else begin
					phase_n = PH_BODY;
				end
			end
			PH_BODY: begin
				rem_n = rem_dec;
				if (rem_le1) begin
					phase_n = PH_SHORT;
				end
				emit         = 1'b1;
				emit_kind    = KIND_BODY;
				emit_payload = data_s1;
				emit_flags   = flags_q;
				emit_last    = rem_le1;
			end
			PH_DISCARD: begin
				rem_n = rem_dec;
				if (rem_le1) begin
					phase_n = PH_SHORT;
				end
			end
			default: begin
				if (data_s1 == ESCAPE_BYTE) begin
					phase_n = PH_LONG;
					lcnt_n  = 3'd0;
					acc_n   = 64'd0;
				end else begin
					len_done = 1'b1;
				end
			end
		endcase
		if (len_done) begin
			if (len_zero) begin
				phase_n   = PH_SHORT;
				rem_n     = 64'd0;
				emit      = 1'b1;
				emit_kind = KIND_ZERO;
			end else if (len_over) begin
				// flags byte plus body are dropped: len words in all
				phase_n   = PH_DISCARD;
				rem_n     = len_w;
				emit      = 1'b1;
				emit_kind = KIND_OVERSIZE;
			end else begin
				phase_n = PH_FLAGS;
				rem_n   = len_m1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SHORT;
			lcnt_q   <= 3'd0;
			acc_q    <= 64'd0;
			rem_q    <= 64'd0;
			flags_q  <= 8'd0;
			max_p1_q <= {1'b0, MAX_BODY_RESET} + 33'd1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_p1_q <= {1'b0, max_body_length} + 33'd1;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				phase_q <= phase_n;
				lcnt_q  <= lcnt_n;
				acc_q   <= acc_n;
				rem_q   <= rem_n;
				flags_q <= flags_n;
			end
			if (advance) begin
				valid_s2 <= emit;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
		end
		if (advance && emit) begin
			kind_s2    <= emit_kind;
			payload_s2 <= emit_payload;
			flags_s2   <= emit_flags;
			last_s2    <= emit_last;
		end
	end

	assign out_valid    = valid_s2;
	assign kind         = kind_s2;
	assign payload_byte = payload_s2;
	assign frame_flags  = flags_s2;
	assign last_byte    = last_s2;

endmodule

[verif/tb_length_prefixed_frame_decoder.sv]
module tb_length_prefixed_frame_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import lpfd_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct {
		kind_t      code;
		logic [7:0] data;
		logic [7:0] flags;
		logic       last;
	} frame_word_t;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte       = 8'h00;
	logic        out_valid;
	logic        out_ready       = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [7:0]  frame_flags;
	logic        last_byte;
	logic        cfg_valid       = 1'b0;
	logic        cfg_ready;
	logic [31:0] max_body_length = 32'd0;

	length_prefixed_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.frame_flags(frame_flags),
		.last_byte(last_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_body_length(max_body_length)
	);

	always #5 clk = ~clk;

	// stream bytes waiting to be sent, decoded words waiting to arrive
	logic [7:0]  tx_bytes[$];
	frame_word_t expected_words[$];

	int sender_idle   = 36;
	int receiver_idle = 84;
	int errors        = 0;
	int cycle_count   = 0;

	// deframer state mirrored on the send side
	phase_t      dec_phase   = PH_SHORT;
	logic [2:0]  long_cnt    = 3'd0;
	logic [63:0] len_acc     = 64'd0;
	logic [63:0] remain      = 64'd0;
	logic [7:0]  flags_q     = 8'h00;
	logic [31:0] limit_model = MAX_BODY_RESET;

	function automatic void expect_word(input kind_t code, input logic [7:0] data,
			input logic [7:0] flags, input logic last);
		frame_word_t w;
		w.code  = code;
		w.data  = data;
		w.flags = flags;
		w.last  = last;
		expected_words.push_back(w);
	endfunction

	// length L complete: zero is an error, oversize is flagged and L bytes dropped
	function automatic void close_length(input logic [63:0] len);
		if (len == 64'd0) begin
			dec_phase = PH_SHORT;
			remain = 64'd0;
			expect_word(KIND_ZERO, 8'h00, 8'h00, 1'b0);
		end else if (len - 64'd1 > {32'd0, limit_model}) begin
			remain = len;
			dec_phase = PH_DISCARD;
			expect_word(KIND_OVERSIZE, 8'h00, 8'h00, 1'b0);
		end else begin
			remain = len - 64'd1;
			dec_phase = PH_FLAGS;
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		logic last_flag;
		case (dec_phase)
			PH_LONG: begin
				len_acc = {len_acc[55:0], b};
				long_cnt = long_cnt + 3'd1;
				if (long_cnt == 3'd0)
					close_length(len_acc);
			end
			PH_FLAGS: begin
				flags_q = b;
				if (remain == 64'd0) begin
					dec_phase = PH_SHORT;
					expect_word(KIND_EMPTY, 8'h00, flags_q, 1'b1);
				end else
					dec_phase = PH_BODY;
			end
			PH_BODY: begin
				last_flag = (remain <= 64'd1);
				if (remain != 64'd0)
					remain = remain - 64'd1;
				if (remain == 64'd0)
					dec_phase = PH_SHORT;
				expect_word(KIND_BODY, b, flags_q, last_flag);
			end
			PH_DISCARD: begin
				if (remain != 64'd0)
					remain = remain - 64'd1;
				if (remain == 64'd0)
					dec_phase = PH_SHORT;
			end
			default: begin
				if (b == ESCAPE_BYTE) begin
					dec_phase = PH_LONG;
					long_cnt = 3'd0;
					len_acc = 64'd0;
				end else
					close_length({56'd0, b});
			end
		endcase
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// sender: predicts on each accepted word, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
		end else begin
			if (in_valid && in_ready)
				decode_byte(data_byte);
			if (!in_valid || in_ready) begin
				if (tx_bytes.size() != 0 && $urandom_range(99) >= sender_idle) begin
					in_valid <= 1'b1;
					data_byte <= tx_bytes.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		frame_word_t exp_w;
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: kind %0d payload %0h", kind, payload_byte);
					errors++;
				end else begin
					exp_w = expected_words.pop_front();
					if (kind !== exp_w.code) begin
						$error("kind: expected %0d, got %0d", exp_w.code, kind);
						errors++;
					end
					if (payload_byte !== exp_w.data) begin
						$error("payload_byte: expected %0h, got %0h", exp_w.data, payload_byte);
						errors++;
					end
					if (frame_flags !== exp_w.flags) begin
						$error("frame_flags: expected %0h, got %0h", exp_w.flags, frame_flags);
						errors++;
					end
					if (last_byte !== exp_w.last) begin
						$error("last_byte: expected %0b, got %0b", exp_w.last, last_byte);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_idle);
		end
	end

	task automatic push_length(input logic [63:0] len, input bit long_form);
		if (long_form || len > 64'd254) begin
			tx_bytes.push_back(ESCAPE_BYTE);
			for (int i = 7; i >= 0; i--)
				tx_bytes.push_back(len[8*i +: 8]);
		end else
			tx_bytes.push_back(len[7:0]);
	endtask

	// random content stays below 0xff so a stream knocked out of step
	// never finds an escape followed by a runaway length
	task automatic push_frame(input int body, input bit long_form);
		push_length(64'(body + 1), long_form);
		tx_bytes.push_back(8'($urandom_range(0, 254)));
		repeat (body)
			tx_bytes.push_back(8'($urandom_range(0, 254)));
	endtask

	task automatic push_random(input int n);
		int base;
		int r;
		int body;
		int span;
		bit long_form;
		base = tx_bytes.size();
		while (tx_bytes.size() - base < n) begin
			span = (limit_model < 60) ? int'(limit_model) + 3 : 40;
			r = $urandom_range(99);
			long_form = ($urandom_range(9) == 0);
			if (r < 55)
				body = $urandom_range(0, span);
			else if (r < 60)
				body = $urandom_range(200, 300);
			else if (r < 68)
				body = (limit_model < 300) ? int'(limit_model) : $urandom_range(0, span);
			else if (r < 76)
				body = (limit_model < 300) ? int'(limit_model) + 1 + $urandom_range(0, 3)
					: $urandom_range(0, span);
			else if (r < 84)
				body = 0;
			else if (r < 92)
				body = -1;
			else
				body = -2;
			if (body == 254)
				body = 253;
			if (body == -1)
				push_length(64'd0, long_form);
			else if (body == -2)
				tx_bytes.push_back(8'($urandom_range(0, 254)));
			else
				push_frame(body, long_form);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (tx_bytes.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		max_body_length <= value;
		do @(posedge clk);
		while (!cfg_ready);
		limit_model = value;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default limit: body with 0xff content, empty body, short and long zero,
		// non-minimal long length
		push_length(64'd3, 1'b0);
		tx_bytes.push_back(8'ha5);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hff);
		push_length(64'd1, 1'b0);
		tx_bytes.push_back(8'h5a);
		push_length(64'd0, 1'b0);
		push_length(64'd0, 1'b1);
		push_length(64'd2, 1'b1);
		tx_bytes.push_back(8'hff);
		tx_bytes.push_back(8'h80);
		wait_drained();

		// limit zero: empty body still fits, one byte is oversize
		write_limit(32'd0);
		push_length(64'd1, 1'b0);
		tx_bytes.push_back(8'h3c);
		push_length(64'd2, 1'b0);
		tx_bytes.push_back(8'h11);
		tx_bytes.push_back(8'h22);
		push_random(150);
		wait_drained();

		sender_idle = 84;
		receiver_idle = 36;
		write_limit(32'($urandom_range(1, 40)));
		push_random(250);
		wait_drained();

		write_limit(32'($urandom_range(0, 8)));
		push_random(200);
		wait_drained();

		sender_idle = 0;
		receiver_idle = 0;
		write_limit(32'hffff_ffff);
		push_random(250);
		// largest long length: oversize even at the top limit, rest is dropped
		push_length(64'hffff_ffff_ffff_ffff, 1'b1);
		repeat (4)
			tx_bytes.push_back(8'($urandom_range(0, 255)));
		wait_drained();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
